// File: rtl/core/pol_pkg.sv
// Shared constants, op codes and the cell command struct for the positional ordered list.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package pol_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 6;
	localparam int FOUND_W  = 5;
	localparam int COUNT_W  = 6;

	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int FWIDE_W  = (IDX_W > FOUND_W) ? IDX_W : FOUND_W;
	localparam int OUTW_W   = (WIDE_W > COUNT_W) ? WIDE_W : COUNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_LAST  = 4'd1,
		OP_INS_AT    = 4'd2,
		OP_DEL_FRONT = 4'd3,
		OP_DEL_LAST  = 4'd4,
		OP_DEL_AT    = 4'd5,
		OP_SEARCH    = 4'd6,
		OP_COUNT     = 4'd7,
		OP_CLEAR     = 4'd8
	} op_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              cap;   // capture match bits and the picked word
		logic              ins;   // open a gap at pos and write val there
		logic              del;   // close the gap at pos
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;   // entries held before the operation
		logic [DATA_W-1:0] val;   // word to insert or key to compare
	} cell_cmd_t;

endpackage

// File: rtl/core/pol_if.sv
// Request and response channel interfaces of the positional ordered list.
// Depends on pol_pkg for field widths.
interface pol_req_if;
	logic                              valid;
	logic                              ready;
	logic [pol_pkg::OP_W-1:0]          op;
	logic signed [pol_pkg::DATA_W-1:0] value;
	logic [pol_pkg::POS_W-1:0]         position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface pol_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              ok;
	logic signed [pol_pkg::DATA_W-1:0] value_out;
	logic [pol_pkg::FOUND_W-1:0]       found_position;
	logic [pol_pkg::COUNT_W-1:0]       element_count;

	modport source (output valid, output ok, output value_out, output found_position,
		output element_count, input ready);
	modport sink   (input valid, input ok, input value_out, input found_position,
		input element_count, output ready);
endinterface

// File: rtl/core/pol_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbours.
// Depends on pol_pkg.
module pol_cell (
	input  logic                       clk,
	input  logic [pol_pkg::IDX_W-1:0]  idx,
	input  pol_pkg::cell_cmd_t         cmd,
	input  logic [pol_pkg::DATA_W-1:0] left,
	input  logic [pol_pkg::DATA_W-1:0] right,
	output logic [pol_pkg::DATA_W-1:0] data,
	output logic                       match,
	output logic [pol_pkg::DATA_W-1:0] pick
);

	logic [pol_pkg::DATA_W-1:0] data_q;
	logic                       after;
	logic                       at;

	assign after = idx > cmd.pos;
	assign at    = idx == cmd.pos;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (after) begin
				data_q <= left;
			end else if (at) begin
				data_q <= cmd.val;
			end
		end else if (cmd.del) begin
			if (after || at) begin
				data_q <= right;
			end
		end
	end

	assign data  = data_q;
	// only live entries may match
	assign match = (data_q == cmd.val) && (pol_pkg::CNT_W'(idx) < cmd.cnt);
	assign pick  = at ? data_q : '0;

endmodule

// File: rtl/core/pol_chain.sv
// Row of list cells with neighbour links, registered match bits and picked-word capture.
// Depends on pol_pkg and pol_cell.
module pol_chain (
	input  logic                          clk,
	input  pol_pkg::cell_cmd_t            cmd,
	output logic [pol_pkg::CAPACITY-1:0]  match_q,
	output logic [pol_pkg::DATA_W-1:0]    picked_q
);

	logic [pol_pkg::DATA_W-1:0] data  [pol_pkg::CAPACITY];
	logic [pol_pkg::DATA_W-1:0] pick  [pol_pkg::CAPACITY];
	logic [pol_pkg::CAPACITY-1:0] match;
	logic [pol_pkg::DATA_W-1:0] picked;

	for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
		logic [pol_pkg::DATA_W-1:0] left;
		logic [pol_pkg::DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = cmd.val;
		end else begin : g_mid_l
			assign left = data[i-1];
		end
		if (i == pol_pkg::CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = data[i+1];
		end

		pol_cell u_cell (
			.clk   (clk),
			.idx   (pol_pkg::IDX_W'(i)),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.data  (data[i]),
			.match (match[i]),
			.pick  (pick[i])
		);
	end

	// at most one cell is selected, so an OR gathers its word
	always_comb begin
		picked = '0;
		for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
			picked = picked | pick[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			match_q  <= match;
			picked_q <= picked;
		end
	end

endmodule

// File: rtl/core/positional_ordered_list.sv
// Top level of the positional ordered list: op decode, count, sequencing and response register.
// Depends on pol_pkg, pol_if (pol_req_if, pol_rsp_if) and pol_chain.
//
//  channel  direction  fields                                             handshake
//  req      in         op[3:0] value[31:0] position[5:0]                  valid/ready
//  rsp      out        ok value_out[31:0] found_position[4:0]
//                      element_count[5:0]                                 valid/ready
//
// Each word is accepted and decoded, then the cell chain shifts and every cell compares its entry
// against the key, then the response state loads the output register. The next request word is
// taken as soon as the response is loaded, even if the previous response is still waiting; no new
// word is taken while one is in the chain or response state.
// arst_n clears the count, the sequencer and the response valid; entries need no clearing since
// only positions below the count are ever read. A stalled rsp holds the sequencer in its
// response cycle and req.ready stays low until the result has somewhere to go.
module positional_ordered_list (
	input  logic clk,
	input  logic arst_n,
	pol_req_if.sink   req,
	pol_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t                        state_q;
	logic [pol_pkg::CNT_W-1:0]     cnt_q;
	logic [pol_pkg::CNT_W-1:0]     cnt_old_q;
	logic                          ok_q;
	logic                          ins_q;
	logic                          del_q;
	logic                          srch_q;
	logic [pol_pkg::IDX_W-1:0]     pos_q;
	logic [pol_pkg::DATA_W-1:0]    val_q;

	logic                          rsp_vld_q;
	logic                          rsp_ok_q;
	logic [pol_pkg::DATA_W-1:0]    rsp_val_q;
	logic [pol_pkg::FOUND_W-1:0]   rsp_found_q;
	logic [pol_pkg::COUNT_W-1:0]   rsp_cnt_q;

	logic                          take;
	logic                          full;
	logic                          empty;
	logic [pol_pkg::WIDE_W-1:0]    cnt_w;
	logic [pol_pkg::WIDE_W-1:0]    pos_w;
	logic [pol_pkg::WIDE_W-1:0]    eff_w;
	logic                          ok_d;
	logic                          ins_d;
	logic                          del_d;

	pol_pkg::cell_cmd_t            cmd;
	logic [pol_pkg::CAPACITY-1:0]  match_q;
	logic [pol_pkg::DATA_W-1:0]    picked_q;
	logic [pol_pkg::CAPACITY-1:0]  first;
	logic [pol_pkg::FWIDE_W-1:0]   found_w;
	logic [pol_pkg::OUTW_W-1:0]    cnt_out_w;
	logic                          rsp_load;

	// ---------------------------------------------------------------- decode
	assign req.ready = state_q == ST_IDLE;
	assign take      = req.valid && req.ready;

	assign full  = cnt_q == pol_pkg::CNT_W'(pol_pkg::CAPACITY);
	assign empty = cnt_q == '0;
	assign cnt_w = pol_pkg::WIDE_W'(cnt_q);
	assign pos_w = pol_pkg::WIDE_W'(req.position);

	always_comb begin
		ok_d  = 1'b0;
		ins_d = 1'b0;
		del_d = 1'b0;
		eff_w = '0;
		unique case (pol_pkg::op_t'(req.op))
			pol_pkg::OP_INS_FRONT: begin
				ok_d  = !full;
				ins_d = 1'b1;
			end
			pol_pkg::OP_INS_LAST: begin
				ok_d  = !full;
				ins_d = 1'b1;
				eff_w = cnt_w;
			end
			pol_pkg::OP_INS_AT: begin
				ok_d  = !full && (pos_w <= cnt_w);
				ins_d = 1'b1;
				eff_w = pos_w;
			end
			pol_pkg::OP_DEL_FRONT: begin
				ok_d  = !empty;
				del_d = 1'b1;
			end
			pol_pkg::OP_DEL_LAST: begin
				ok_d  = !empty;
				del_d = 1'b1;
				eff_w = cnt_w - pol_pkg::WIDE_W'(1);
			end
			pol_pkg::OP_DEL_AT: begin
				ok_d  = pos_w < cnt_w;
				del_d = 1'b1;
				eff_w = pos_w;
			end
			pol_pkg::OP_COUNT,
			pol_pkg::OP_CLEAR: begin
				ok_d = 1'b1;
			end
			default: begin
				// search settles ok later; unused codes drop through as a failed no-op
				ok_d = 1'b0;
			end
		endcase
	end

	// -------------------------------------------------------------- sequencer
	assign rsp_load = (state_q == ST_RESP) && (!rsp_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_EXEC;
						if (pol_pkg::op_t'(req.op) == pol_pkg::OP_CLEAR) begin
							cnt_q <= '0;
						end else if (ok_d && ins_d) begin
							cnt_q <= cnt_q + pol_pkg::CNT_W'(1);
						end else if (ok_d && del_d) begin
							cnt_q <= cnt_q - pol_pkg::CNT_W'(1);
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the decoded word for the chain and response cycles
	always_ff @(posedge clk) begin
		if (take) begin
			ok_q      <= ok_d;
			ins_q     <= ok_d && ins_d;
			del_q     <= ok_d && del_d;
			srch_q    <= pol_pkg::op_t'(req.op) == pol_pkg::OP_SEARCH;
			pos_q     <= eff_w[pol_pkg::IDX_W-1:0];
			val_q     <= req.value;
			cnt_old_q <= cnt_q;
		end
	end

	// ------------------------------------------------------------- cell chain
	assign cmd.cap = state_q == ST_EXEC;
	assign cmd.ins = ins_q && (state_q == ST_EXEC);
	assign cmd.del = del_q && (state_q == ST_EXEC);
	assign cmd.pos = pos_q;
	assign cmd.cnt = cnt_old_q;
	assign cmd.val = val_q;

	pol_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.match_q  (match_q),
		.picked_q (picked_q)
	);

	// isolate the lowest match, then gather its index
	assign first = match_q & (~match_q + pol_pkg::CAPACITY'(1));

	always_comb begin
		found_w = '0;
		for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
			if (first[i]) begin
				found_w = found_w | pol_pkg::FWIDE_W'(i);
			end
		end
	end

	assign cnt_out_w = pol_pkg::OUTW_W'(cnt_q);

	// -------------------------------------------------------- response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_ok_q    <= srch_q ? (match_q != '0) : ok_q;
			rsp_val_q   <= del_q ? picked_q : '0;
			rsp_found_q <= (srch_q && (match_q != '0)) ? found_w[pol_pkg::FOUND_W-1:0] : '0;
			rsp_cnt_q   <= cnt_out_w[pol_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.value_out      = rsp_val_q;
	assign rsp.found_position = rsp_found_q;
	assign rsp.element_count  = rsp_cnt_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
		else $error("list count above capacity");

	a_exec_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_RESP)
		else $error("chain cycle not followed by response cycle");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && !(srch_q ? (match_q != '0) : ok_q) |=>
		rsp.value_out == '0 && rsp.found_position == '0)
		else $error("failed word carries a value or a position");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.op == pol_pkg::OP_CLEAR |=> cnt_q == '0)
		else $error("clear left entries behind");
`endif

endmodule
